>>> hw/rtl/ecd_pkg.sv
// ----------------------------------------------------------------------------
// Event channel dispatcher package
// Shared types, constants and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package ecd_pkg;

	localparam int WORD_BITS_DEF  = 64;
	localparam int NUM_WORDS_DEF  = 8;
	localparam int NUM_LEVELS_DEF = 8;
	localparam int PORT_SLOTS     = 512;
	localparam int PORT_W         = 9;
	localparam int PRIO_W         = 3;
	localparam int UNIT_W         = 16;

	typedef enum logic [1:0] {
		KIND_BIND    = 2'd0,
		KIND_RAISE   = 2'd1,
		KIND_MASK    = 2'd2,
		KIND_SERVICE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [PORT_W-1:0]  port;
		logic [PRIO_W-1:0]  priority_req;
		logic [UNIT_W-1:0]  unit;
		logic               mask_value;
	} req_t;

	typedef struct packed {
		logic               dispatched;
		logic [PORT_W-1:0]  event_port;
		logic               is_bound;
		logic [UNIT_W-1:0]  event_unit;
		logic [PRIO_W-1:0]  event_priority;
		logic               upcall_flag;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic emit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_service;
		logic found;
		logic sel_empty;
	} ctl_sts_t;

endpackage

>>> hw/rtl/event_channel_dispatcher.sv
// ----------------------------------------------------------------------------
// Event channel dispatcher
// Two-level pending event dispatcher with bind, raise, mask and service.
// ----------------------------------------------------------------------------
// Bind, raise and mask pass through the execute, read and done states; a service
// also walks the snapshot words it examines (at most NUM_WORDS). One request at a time,
// so the next request is taken once the previous one has finished.
// The result is shown for one cycle with done and cannot be stalled.
// Reset clears all event state; the port table memory is not cleared, and an
// unbound port reports unit and priority as zero.
module event_channel_dispatcher import ecd_pkg::*; #(
	parameter int WORD_BITS  = WORD_BITS_DEF,
	parameter int NUM_WORDS  = NUM_WORDS_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ecd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	ecd_dp #(
		.WORD_BITS  (WORD_BITS),
		.NUM_WORDS  (NUM_WORDS),
		.NUM_LEVELS (NUM_LEVELS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.strobe (done),
		.rsp    (rsp)
	);

endmodule

>>> hw/rtl/ecd_ctrl.sv
// ----------------------------------------------------------------------------
// Event channel dispatcher controller
// Sequences one request: execute, scan snapshot words, read port table, reply.
// ----------------------------------------------------------------------------
module ecd_ctrl import ecd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// This state executes the request; the snapshot words are scanned in ST_READ.
				cmd.exec = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				// Walk the snapshot one word per cycle until a hit or empty; other kinds go to done.
				if (!sts.is_service || sts.found || sts.sel_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/ecd_dp.sv
// ----------------------------------------------------------------------------
// Event channel dispatcher datapath
// Pending and mask words, selectors, port table memory and result register.
// ----------------------------------------------------------------------------
module ecd_dp import ecd_pkg::*; #(
	parameter int WORD_BITS  = WORD_BITS_DEF,
	parameter int NUM_WORDS  = NUM_WORDS_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output logic     strobe,
	output rsp_t     rsp
);

	localparam int BIT_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int WIDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int LIMIT   = WORD_BITS * NUM_WORDS;
	localparam int LIM_W   = $clog2(LIMIT + 1) + 1;
	localparam int TOP_LVL = NUM_LEVELS - 1;

	req_t                  req_q;
	logic [WORD_BITS-1:0]  pend_q [NUM_WORDS];
	logic [WORD_BITS-1:0]  mask_q [NUM_WORDS];
	logic [NUM_WORDS-1:0]  shsel_q, wsel_q;
	logic                  upcall_q;
	logic [PORT_SLOTS-1:0] bound_q;
	logic [PRIO_W+UNIT_W-1:0] tab_mem [PORT_SLOTS];
	logic [PRIO_W+UNIT_W-1:0] tab_rd_q;
	logic                  found_q;
	logic [PORT_W-1:0]     hit_port_q;
	logic                  hit_bound_q;
	logic                  strobe_q;
	rsp_t                  rsp_q;

	// Request decode.
	logic                  ok;
	logic [WIDX_W-1:0]     widx;
	logic [BIT_W-1:0]      bidx;
	logic [PRIO_W-1:0]     prio_sat;
	assign ok   = ({{(LIM_W-PORT_W){1'b0}}, req_q.port} < LIM_W'(LIMIT));
	assign prio_sat = ({1'b0, req_q.priority_req} > (PRIO_W+1)'(TOP_LVL)) ?
		PRIO_W'(TOP_LVL) : req_q.priority_req;

	// Word index by comparison against word boundaries, bit index as the remainder.
	always_comb begin
		widx = '0;
		for (int i = 1; i < NUM_WORDS; i++) begin
			if ({{(LIM_W-PORT_W){1'b0}}, req_q.port} >= LIM_W'(i * WORD_BITS))
				widx = WIDX_W'(i);
		end
		bidx = BIT_W'(req_q.port - PORT_W'(widx * WORD_BITS));
	end

	// Lowest word in the snapshot, and the lowest available bit in it.
	logic [NUM_WORDS-1:0]  eff_sel;
	logic [WIDX_W-1:0]     cur_w;
	logic [WORD_BITS-1:0]  avail;
	logic [BIT_W-1:0]      low_b;
	always_comb begin
		eff_sel = wsel_q;
		cur_w   = '0;
		for (int i = NUM_WORDS - 1; i >= 0; i--) begin
			if (eff_sel[i]) cur_w = WIDX_W'(i);
		end
		avail = pend_q[cur_w] & ~mask_q[cur_w];
		low_b = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (avail[j]) low_b = BIT_W'(j);
		end
	end

	logic [PORT_W-1:0] hit_port;
	assign hit_port = PORT_W'(cur_w * WORD_BITS) + PORT_W'(low_b);

	assign sts.is_service = (req_q.kind == KIND_SERVICE);
	assign sts.found      = found_q;
	assign sts.sel_empty  = (wsel_q == '0);

	// Request register.
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	// Event state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_WORDS; k++) begin
				pend_q[k] <= '0;
				mask_q[k] <= '0;
			end
			shsel_q     <= '0;
			wsel_q      <= '0;
			upcall_q    <= 1'b0;
			bound_q     <= '0;
			found_q     <= 1'b0;
			hit_port_q  <= '0;
			hit_bound_q <= 1'b0;
		end else begin
			if (cmd.load) found_q <= 1'b0;
			if (cmd.exec) begin
				case (req_q.kind)
					KIND_BIND: if (ok) bound_q[req_q.port] <= 1'b1;
					KIND_RAISE: if (ok) begin
						pend_q[widx][bidx] <= 1'b1;
						if (!mask_q[widx][bidx]) begin
							shsel_q[widx] <= 1'b1;
							upcall_q      <= 1'b1;
						end
					end
					KIND_MASK: if (ok) mask_q[widx][bidx] <= req_q.mask_value;
					default: begin
						upcall_q <= 1'b0;
						if (wsel_q == '0) begin
							wsel_q  <= shsel_q;
							shsel_q <= '0;
						end
					end
				endcase
			end
			// One snapshot word per cycle: hit, or drop the empty word.
			if (cmd.scan) begin
				if (avail != '0) begin
					pend_q[cur_w][low_b] <= 1'b0;
					found_q     <= 1'b1;
					hit_port_q  <= hit_port;
					hit_bound_q <= bound_q[hit_port];
				end else begin
					wsel_q[cur_w] <= 1'b0;
				end
			end
		end
	end

	// Port table memory, read at the captured hit port.
	always_ff @(posedge clk) begin
		if (cmd.exec && req_q.kind == KIND_BIND && ok)
			tab_mem[req_q.port] <= {prio_sat, req_q.unit};
		tab_rd_q <= tab_mem[hit_port_q];
	end

	// Result register. An unbound port reports unit and priority as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe_q <= 1'b0;
		else         strobe_q <= cmd.emit;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.dispatched     <= found_q;
			rsp_q.event_port     <= found_q ? hit_port_q : '0;
			rsp_q.is_bound       <= found_q & hit_bound_q;
			rsp_q.event_unit     <= (found_q && hit_bound_q) ?
				tab_rd_q[UNIT_W-1:0] : '0;
			rsp_q.event_priority <= (found_q && hit_bound_q) ?
				tab_rd_q[PRIO_W+UNIT_W-1:UNIT_W] : '0;
			rsp_q.upcall_flag    <= upcall_q;
		end
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule
